/* rtl/spi_flash_read_master_defines.svh */
// Assertion macros shared by the SPI flash read master modules.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef SPI_FLASH_READ_MASTER_DEFINES_SVH
`define SPI_FLASH_READ_MASTER_DEFINES_SVH

// Same-cycle implication.
`define SFRM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SFRM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sfrm_pkg.sv */
`timescale 1ns / 1ps

package sfrm_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 8;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_READ_OP = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_FAST_OP = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_ID_OP   = 2'd2;

  localparam logic [7:0] READ_OP_RST = 8'h03;
  localparam logic [7:0] FAST_OP_RST = 8'h0B;
  localparam logic [7:0] ID_OP_RST   = 8'h9F;

  // Command codes; any other code is a plain tick.
  localparam logic [1:0] CMD_READ = 2'd1;
  localparam logic [1:0] CMD_ID   = 2'd2;

  localparam logic [15:0] DEFAULT_LENGTH = 16'd256;
  localparam logic [15:0] ID_BYTES       = 16'd3;

  localparam logic [2:0] ID_HDR_LEN   = 3'd1;
  localparam logic [2:0] READ_HDR_LEN = 3'd4;
  localparam logic [2:0] FAST_HDR_LEN = 3'd5;

  localparam logic [7:0] DUMMY_BYTE = 8'h00;

  typedef struct packed {
    logic [7:0] read_op;
    logic [7:0] fast_op;
    logic [7:0] id_op;
  } opcodes_t;

  typedef struct packed {
    logic       cs_n;
    logic       sclk;
    logic       mosi;
    logic       byte_valid;
    logic [7:0] byte_value;
    logic       last_byte;
    logic       busy;
  } result_t;

  // Byte sent at a given position of the command header.
  function automatic logic [7:0] header_byte(logic [2:0] idx, logic is_id, logic is_fast,
                                             logic [23:0] addr, opcodes_t ops);
    logic [7:0] b;
    if (is_id) begin
      b = ops.id_op;
    end else begin
      case (idx)
        3'd0:    b = is_fast ? ops.fast_op : ops.read_op;
        3'd1:    b = addr[23:16];
        3'd2:    b = addr[15:8];
        3'd3:    b = addr[7:0];
        default: b = DUMMY_BYTE;
      endcase
    end
    return b;
  endfunction

endpackage

/* rtl/sfrm_cfg.sv */
`timescale 1ns / 1ps

module sfrm_cfg
  import sfrm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output opcodes_t            ops_o
);

  opcodes_t ops_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ops_q.read_op <= READ_OP_RST;
      ops_q.fast_op <= FAST_OP_RST;
      ops_q.id_op   <= ID_OP_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_READ_OP: ops_q.read_op <= cfg_wdata_i;
        REG_FAST_OP: ops_q.fast_op <= cfg_wdata_i;
        REG_ID_OP:   ops_q.id_op   <= cfg_wdata_i;
        default:     ;
      endcase
    end
  end

  assign ops_o = ops_q;

endmodule

/* rtl/sfrm_seq.sv */
`timescale 1ns / 1ps

module sfrm_seq
  import sfrm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [1:0]  command_i,
  input  logic [23:0] address_i,
  input  logic [15:0] length_i,
  input  logic        fast_mode_i,
  input  logic        miso_i,
  input  opcodes_t    ops_i,
  output result_t     result_o
);

`include "spi_flash_read_master_defines.svh"

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SEND,
    PH_RECV
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [2:0]  hidx_q, hidx_d;
  logic [2:0]  bcnt_q, bcnt_d;
  logic        half_q, half_d;
  logic [7:0]  tx_q, tx_d;
  logic [7:0]  rx_q, rx_d;
  logic [23:0] addr_q, addr_d;
  logic [15:0] left_q, left_d;
  logic        fast_q, fast_d;
  logic        id_q, id_d;
  logic        mosi_q, mosi_d;
  logic [2:0]  hdr_len;
  result_t     res;

  always_comb begin
    phase_d = phase_q;
    hidx_d  = hidx_q;
    bcnt_d  = bcnt_q;
    half_d  = half_q;
    tx_d    = tx_q;
    rx_d    = rx_q;
    addr_d  = addr_q;
    left_d  = left_q;
    fast_d  = fast_q;
    id_d    = id_q;
    mosi_d  = mosi_q;

    res            = '0;
    res.cs_n       = 1'b1;

    // A start request on an idle tick loads the transfer and runs its first tick at once.
    if (phase_q == PH_IDLE && (command_i == CMD_READ || command_i == CMD_ID)) begin
      id_d   = (command_i == CMD_ID);
      fast_d = id_d ? 1'b0 : fast_mode_i;
      addr_d = id_d ? 24'd0 : address_i;
      if (id_d) begin
        left_d = ID_BYTES;
      end else begin
        left_d = (length_i == 16'd0) ? DEFAULT_LENGTH : length_i;
      end
      hidx_d  = 3'd0;
      bcnt_d  = 3'd0;
      half_d  = 1'b0;
      rx_d    = 8'd0;
      tx_d    = header_byte(3'd0, id_d, fast_d, addr_d, ops_i);
      phase_d = PH_SEND;
    end

    hdr_len = id_d ? ID_HDR_LEN : (fast_d ? FAST_HDR_LEN : READ_HDR_LEN);

    case (phase_d)
      PH_SEND: begin
        res.cs_n = 1'b0;
        res.busy = 1'b1;
        if (!half_d) begin
          mosi_d = tx_d[7];
          half_d = 1'b1;
        end else begin
          res.sclk = 1'b1;
          half_d   = 1'b0;
          tx_d     = {tx_d[6:0], 1'b0};
          bcnt_d   = bcnt_d + 3'd1;
          if (bcnt_d == 3'd0) begin
            hidx_d = hidx_d + 3'd1;
            if (hidx_d < hdr_len) begin
              tx_d = header_byte(hidx_d, id_d, fast_d, addr_d, ops_i);
            end else begin
              phase_d = PH_RECV;
              rx_d    = 8'd0;
            end
          end
        end
      end
      PH_RECV: begin
        res.cs_n = 1'b0;
        res.busy = 1'b1;
        if (!half_d) begin
          res.sclk = 1'b1;
          rx_d     = {rx_d[6:0], miso_i};
          half_d   = 1'b1;
        end else begin
          half_d = 1'b0;
          bcnt_d = bcnt_d + 3'd1;
          if (bcnt_d == 3'd0) begin
            res.byte_valid = 1'b1;
            res.byte_value = rx_d;
            left_d         = left_d - 16'd1;
            if (left_d == 16'd0) begin
              res.last_byte = 1'b1;
              phase_d       = PH_IDLE;
            end
            rx_d = 8'd0;
          end
        end
      end
      default: ;
    endcase

    res.mosi = mosi_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      hidx_q  <= 3'd0;
      bcnt_q  <= 3'd0;
      half_q  <= 1'b0;
      tx_q    <= 8'd0;
      rx_q    <= 8'd0;
      addr_q  <= 24'd0;
      left_q  <= 16'd0;
      fast_q  <= 1'b0;
      id_q    <= 1'b0;
      mosi_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      hidx_q  <= hidx_d;
      bcnt_q  <= bcnt_d;
      half_q  <= half_d;
      tx_q    <= tx_d;
      rx_q    <= rx_d;
      addr_q  <= addr_d;
      left_q  <= left_d;
      fast_q  <= fast_d;
      id_q    <= id_d;
      mosi_q  <= mosi_d;
    end
  end

  assign result_o = res;

  // Between transfers the bit and half-period counters have wrapped back to zero.
  `SFRM_ASSERT_NOW(a_idle_counters, phase_q == PH_IDLE, half_q == 1'b0 && bcnt_q == 3'd0, "idle with counters not at zero")
  // Receiving always has at least one byte outstanding.
  `SFRM_ASSERT_NOW(a_recv_left, phase_q == PH_RECV, left_q != 16'd0, "receiving with no bytes left")
  `SFRM_ASSERT_NEXT(a_start_send, step_i && phase_q == PH_IDLE && (command_i == CMD_READ || command_i == CMD_ID), phase_q == PH_SEND, "start request did not enter the send phase")

endmodule

/* rtl/spi_flash_read_master.sv */
`timescale 1ns / 1ps

// Channel | Direction | Handshake             | Payload
// --------+-----------+-----------------------+-------------------------------------------
// in      | to block  | in_valid_i/in_stall_o | command, address, length, fast_mode, miso
// out     | from block| out_valid_o/out_stall_i| cs_n, sclk, mosi, byte_valid, byte_value,
//         |           |                       | last_byte, busy_res
// cfg     | to block  | cfg_we_i              | cfg_index_i, cfg_wdata_i
//
// Each request is one SPI half-period; one request per cycle is accepted while in_stall_o is low.
// The result of an accepted request is held in the output register from the next cycle on.
// The single output register sets the rate: in_stall_o is high only while it holds an
// untaken result and out_stall_i is high.
// Reset clears the sequencer to idle and loads the default opcodes.

module spi_flash_read_master
  import sfrm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          command_i,
  input  logic [23:0]         address_i,
  input  logic [15:0]         length_i,
  input  logic                fast_mode_i,
  input  logic                miso_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                cs_n_o,
  output logic                sclk_o,
  output logic                mosi_o,
  output logic                byte_valid_o,
  output logic [7:0]          byte_value_o,
  output logic                last_byte_o,
  output logic                busy_res_o
);

`include "spi_flash_read_master_defines.svh"

  opcodes_t ops;
  result_t  res;
  result_t  out_q;
  logic     out_valid_q;
  logic     in_fire;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_fire    = in_valid_i && !in_stall_o;

  sfrm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ops_o       (ops)
  );

  sfrm_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_fire),
    .command_i   (command_i),
    .address_i   (address_i),
    .length_i    (length_i),
    .fast_mode_i (fast_mode_i),
    .miso_i      (miso_i),
    .ops_i       (ops),
    .result_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= in_fire || in_stall_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cs_n_o       = out_q.cs_n;
  assign sclk_o       = out_q.sclk;
  assign mosi_o       = out_q.mosi;
  assign byte_valid_o = out_q.byte_valid;
  assign byte_value_o = out_q.byte_value;
  assign last_byte_o  = out_q.last_byte;
  assign busy_res_o   = out_q.busy;

  // Chip select and busy always describe the same transfer state.
  `SFRM_ASSERT_NOW(a_busy_cs, out_valid_o, busy_res_o == !cs_n_o, "busy and chip select disagree")

endmodule

/* tb/sv/spi_flash_read_master_test.sv */
`timescale 1ns / 1ps

module spi_flash_read_master_test;
  import sfrm_pkg::*;

  localparam int unsigned HoldCycles = 400;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandomTicks = 150;

  // Command code 0 is a plain tick; code 3 has no meaning and must act as one too.
  localparam logic [1:0] CMD_PLAIN = 2'd0;
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;

  typedef enum logic [1:0] {SEQ_IDLE, SEQ_SEND, SEQ_RECV} seq_phase_e;
  typedef enum int {MISO_RANDOM, MISO_LOW, MISO_HIGH} miso_pattern_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [23:0] address;
    logic [15:0] length;
    logic        fast_mode;
    logic        miso;
  } spi_tick_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [1:0]          command_i = '0;
  logic [23:0]         address_i = '0;
  logic [15:0]         length_i = '0;
  logic                fast_mode_i = 1'b0;
  logic                miso_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                cs_n_o;
  logic                sclk_o;
  logic                mosi_o;
  logic                byte_valid_o;
  logic [7:0]          byte_value_o;
  logic                last_byte_o;
  logic                busy_res_o;

  spi_flash_read_master DUT (.*);

  always #5 clk_i = ~clk_i;

  spi_tick_t pending_ticks[$];
  result_t   expected_pins[$];
  int unsigned ticks_queued = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned hold_left;
  int unsigned hold_kick = 0;
  int unsigned hold_seen;
  bit send_gaps = 1'b1;
  bit recv_stalls = 1'b1;

  // Shadow of the sequencer and of the opcode registers.
  seq_phase_e  seq_phase;
  logic [2:0]  hdr_idx;
  logic [2:0]  bit_cnt;
  logic        half_q;
  logic [7:0]  tx_sh;
  logic [7:0]  rx_sh;
  logic [23:0] addr_q;
  logic [15:0] left_q;
  logic        fast_q;
  logic        id_q;
  logic        mosi_q;
  logic [7:0]  op_read;
  logic [7:0]  op_fast;
  logic [7:0]  op_id;

  function automatic logic [7:0] hdr_byte(logic [2:0] idx);
    if (id_q) return op_id;
    case (idx)
      3'd0:    return fast_q ? op_fast : op_read;
      3'd1:    return addr_q[23:16];
      3'd2:    return addr_q[15:8];
      3'd3:    return addr_q[7:0];
      default: return DUMMY_BYTE;
    endcase
  endfunction

  function automatic result_t predict_pins(spi_tick_t t);
    result_t r;
    logic [2:0] hdr_len;
    r = '0;
    r.cs_n = 1'b1;
    if (seq_phase == SEQ_IDLE && (t.command == CMD_READ || t.command == CMD_ID)) begin
      id_q = (t.command == CMD_ID);
      fast_q = id_q ? 1'b0 : t.fast_mode;
      addr_q = id_q ? '0 : t.address;
      if (id_q) left_q = ID_BYTES;
      else left_q = (t.length == '0) ? DEFAULT_LENGTH : t.length;
      hdr_idx = '0;
      bit_cnt = '0;
      half_q = 1'b0;
      rx_sh = '0;
      tx_sh = hdr_byte(3'd0);
      seq_phase = SEQ_SEND;
    end
    hdr_len = id_q ? ID_HDR_LEN : (fast_q ? FAST_HDR_LEN : READ_HDR_LEN);
    case (seq_phase)
      SEQ_SEND: begin
        r.cs_n = 1'b0;
        r.busy = 1'b1;
        if (!half_q) begin
          mosi_q = tx_sh[7];
          half_q = 1'b1;
        end else begin
          r.sclk = 1'b1;
          half_q = 1'b0;
          tx_sh = {tx_sh[6:0], 1'b0};
          bit_cnt = bit_cnt + 3'd1;
          if (bit_cnt == '0) begin
            hdr_idx = hdr_idx + 3'd1;
            if (hdr_idx < hdr_len) begin
              tx_sh = hdr_byte(hdr_idx);
            end else begin
              seq_phase = SEQ_RECV;
              rx_sh = '0;
            end
          end
        end
      end
      SEQ_RECV: begin
        r.cs_n = 1'b0;
        r.busy = 1'b1;
        if (!half_q) begin
          r.sclk = 1'b1;
          rx_sh = {rx_sh[6:0], t.miso};
          half_q = 1'b1;
        end else begin
          half_q = 1'b0;
          bit_cnt = bit_cnt + 3'd1;
          if (bit_cnt == '0) begin
            r.byte_valid = 1'b1;
            r.byte_value = rx_sh;
            left_q = left_q - 16'd1;
            if (left_q == '0) begin
              r.last_byte = 1'b1;
              seq_phase = SEQ_IDLE;
            end
            rx_sh = '0;
          end
        end
      end
      default: ;
    endcase
    r.mosi = mosi_q;
    return r;
  endfunction

  function automatic void check_pin(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  function automatic int unsigned random_pause();
    return ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3) : $urandom_range(15, 60);
  endfunction

  function automatic logic miso_level(miso_pattern_e pat);
    case (pat)
      MISO_LOW:  return 1'b0;
      MISO_HIGH: return 1'b1;
      default:   return 1'($urandom_range(0, 1));
    endcase
  endfunction

  // A tick that never starts a transfer, with address, length and fast mode random and miso set by the pattern.
  function automatic spi_tick_t random_tick(miso_pattern_e pat);
    spi_tick_t t;
    t.command = ($urandom_range(0, 3) == 0) ? CMD_SPARE : CMD_PLAIN;
    t.address = 24'($urandom_range(24'hFFFFFF, 0));
    t.length = 16'($urandom_range(16'hFFFF, 0));
    t.fast_mode = 1'($urandom_range(0, 1));
    t.miso = miso_level(pat);
    return t;
  endfunction

  // Queues a start request and exactly as many ticks as the transfer runs, then a short idle tail.
  task automatic queue_transfer(input logic [1:0] cmd, input logic [23:0] addr,
                                input logic [15:0] len, input logic fast,
                                input miso_pattern_e pat);
    spi_tick_t t;
    int unsigned nbytes;
    int unsigned hdr;
    int unsigned active;
    int unsigned tail;
    nbytes = (cmd == CMD_ID) ? ID_BYTES : ((len == '0) ? DEFAULT_LENGTH : len);
    hdr = (cmd == CMD_ID) ? ID_HDR_LEN : (fast ? FAST_HDR_LEN : READ_HDR_LEN);
    active = 16 * (hdr + nbytes);
    tail = $urandom_range(0, 2);
    t = '{command: cmd, address: addr, length: len, fast_mode: fast, miso: miso_level(pat)};
    pending_ticks.push_back(t);
    for (int i = 1; i < active; i++) begin
      t = random_tick(pat);
      // Now and then a start request lands mid-transfer; the block must ignore it.
      if ($urandom_range(0, 99) < 5) t.command = 2'($urandom_range(1, 3));
      pending_ticks.push_back(t);
    end
    repeat (tail) pending_ticks.push_back(random_tick(MISO_RANDOM));
    ticks_queued += active + tail;
  endtask

  // Returns once every request is answered and the SPI sequencer is back to idle.
  task automatic settle();
    do begin
      while (pending_ticks.size() != 0 || in_valid_i || expected_pins.size() != 0)
        @(negedge clk_i);
      if (seq_phase != SEQ_IDLE) repeat (16) pending_ticks.push_back(random_tick(MISO_RANDOM));
    end while (seq_phase != SEQ_IDLE);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_opcode(input logic [CfgIdxW-1:0] idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : driver
    spi_tick_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      {command_i, address_i, length_i, fast_mode_i, miso_i} <= '0;
      gap_left <= 0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (gap_left != 0) begin
        in_valid_i <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_ticks.size() != 0) begin
        nxt = pending_ticks.pop_front();
        {command_i, address_i, length_i, fast_mode_i, miso_i} <= nxt;
        in_valid_i <= 1'b1;
        gap_left <= (send_gaps && $urandom_range(0, 99) < 35) ? random_pause() : 0;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : receiver
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_kick) begin
      hold_seen <= hold_kick;
      hold_left <= HoldCycles - 1;
      out_stall_i <= 1'b1;
    end else if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (recv_stalls && $urandom_range(0, 99) < 25) begin
      out_stall_i <= 1'b1;
      stall_left <= random_pause() - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    result_t want;
    if (!rst_ni) begin
      seq_phase = SEQ_IDLE;
      hdr_idx = '0;
      bit_cnt = '0;
      half_q = 1'b0;
      tx_sh = '0;
      rx_sh = '0;
      addr_q = '0;
      left_q = '0;
      fast_q = 1'b0;
      id_q = 1'b0;
      mosi_q = 1'b0;
      op_read = READ_OP_RST;
      op_fast = FAST_OP_RST;
      op_id = ID_OP_RST;
      expected_pins.delete();
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_pins.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("%0t: pin result with no request pending", $time);
        end else begin
          want = expected_pins.pop_front();
          check_pin("cs_n", want.cs_n, cs_n_o);
          check_pin("sclk", want.sclk, sclk_o);
          check_pin("mosi", want.mosi, mosi_o);
          check_pin("byte_valid", want.byte_valid, byte_valid_o);
          check_pin("byte_value", want.byte_value, byte_value_o);
          check_pin("last_byte", want.last_byte, last_byte_o);
          check_pin("busy_res", want.busy, busy_res_o);
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_READ_OP: op_read = cfg_wdata_i;
          REG_FAST_OP: op_fast = cfg_wdata_i;
          REG_ID_OP:   op_id = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        expected_pins.push_back(predict_pins('{command: command_i, address: address_i,
            length: length_i, fast_mode: fast_mode_i, miso: miso_i}));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned random_start;
    int unsigned phase_no;
    logic [1:0] cmd;
    logic [15:0] len;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Idle ticks first, then an ID transfer and a fast read with the reset opcodes.
    repeat (3) pending_ticks.push_back(random_tick(MISO_RANDOM));
    queue_transfer(CMD_ID, 24'h123456, 16'hFFFF, 1'b1, MISO_RANDOM);
    queue_transfer(CMD_READ, 24'hFFFFFF, 16'd1, 1'b1, MISO_LOW);
    settle();

    write_opcode(REG_READ_OP, 8'h00);
    write_opcode(REG_FAST_OP, 8'h00);
    write_opcode(REG_ID_OP, 8'h00);
    // A write to the unused index must leave all opcodes alone.
    write_opcode(REG_UNUSED, 8'hFF);
    @(negedge clk_i);
    queue_transfer(CMD_ID, 24'hFFFFFF, 16'd0, 1'b0, MISO_RANDOM);
    queue_transfer(CMD_READ, 24'h000000, 16'd1, 1'b0, MISO_HIGH);
    settle();

    write_opcode(REG_READ_OP, 8'hFF);
    write_opcode(REG_FAST_OP, 8'hFF);
    write_opcode(REG_ID_OP, 8'hFF);
    @(negedge clk_i);
    queue_transfer(CMD_ID, 24'h000000, 16'h8000, 1'b1, MISO_HIGH);
    queue_transfer(CMD_READ, 24'h7FFFFF, 16'd1, 1'b1, MISO_RANDOM);
    settle();

    random_start = ticks_queued;
    phase_no = 0;
    while (ticks_queued - random_start < RandomTicks || phase_no < 3) begin
      write_opcode(REG_READ_OP, 8'($urandom));
      write_opcode(REG_FAST_OP, 8'($urandom));
      write_opcode(REG_ID_OP, 8'($urandom));
      @(negedge clk_i);
      // The first phase runs without idling; the second holds the receiver off for
      // a long stretch while requests keep coming, so the input backs up.
      send_gaps = (phase_no > 1);
      recv_stalls = (phase_no != 0);
      if (phase_no == 1) hold_kick++;
      cmd = ($urandom_range(0, 99) < 70) ? CMD_READ : CMD_ID;
      len = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(1, 2))
                                         : 16'($urandom_range(3, 6));
      queue_transfer(cmd, 24'($urandom_range(24'hFFFFFF, 0)), len,
                     1'($urandom_range(0, 1)), MISO_RANDOM);
      settle();
      phase_no++;
    end

    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && expected_pins.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
